[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition that must never be true.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_PROP(lbl, !(cond))

`endif

[rtl/dcp_pkg.sv]
// ----------------------------------------------------------------------------
// dcp_pkg
// Types and constants of the distance constraint projection block.
// ----------------------------------------------------------------------------
package dcp_pkg;

  // Stiffness of one in Q1.16
  localparam logic [16:0] Q_ONE = 17'd65536;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Back pipeline stages (register index of each step's result)
  localparam int NSTAGE    = 69;
  localparam int ST_SUM    = 1;
  localparam int ST_ADIV0  = 1;
  localparam int ST_ADIV1  = 31;
  localparam int ST_SQRT0  = 2;
  localparam int ST_SQRT1  = 34;
  localparam int ST_SDIFF  = 35;
  localparam int ST_FM     = 36;
  localparam int ST_UDIV0  = 36;
  localparam int ST_UDIV1  = 66;
  localparam int ST_E      = 67;
  localparam int ST_MV     = 68;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_APPLIED   = 2'd0,
    ST_ZERO_LEN  = 2'd1,
    ST_ZERO_WSUM = 2'd2,
    ST_SATURATED = 2'd3
  } dcp_status_e;

  // Classified request as it sits in the queue
  typedef struct packed {
    logic [2:0][31:0] p1;
    logic [2:0][31:0] p2;
    logic [2:0][32:0] mag;
    logic [2:0]       dneg;
    logic [30:0]      w1;
    logic [30:0]      w2;
    logic [31:0]      wsum;
    logic [30:0]      rest;
    logic [16:0]      k;
  } dcp_item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } dcp_q_stat_t;

  // One back pipeline stage
  typedef struct packed {
    dcp_item_t        it;
    logic [2:0][64:0] sq;
    logic [65:0]      rem;
    logic [32:0]      root;
    logic [1:0][33:0] ar;
    logic [1:0][30:0] aq;
    logic             sneg;
    logic [32:0]      sabs;
    logic [32:0]      fm;
    logic [2:0][34:0] ur;
    logic [2:0][30:0] uq;
    logic [2:0][32:0] e;
    logic [2:0][32:0] mv1;
    logic [2:0][32:0] mv2;
  } dcp_pipe_t;

  // Result request
  typedef struct packed {
    logic [2:0][31:0] n1;
    logic [2:0][31:0] n2;
    dcp_status_e      status;
  } dcp_res_t;

endpackage

[rtl/dcp_front.sv]
// ----------------------------------------------------------------------------
// dcp_front
// Accepts requests, forms the point difference, weight sum and clamped
// stiffness, and pushes the classified request into the queue.
// ----------------------------------------------------------------------------
module dcp_front import dcp_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] first_x_i,
  input  logic [31:0] first_y_i,
  input  logic [31:0] first_z_i,
  input  logic [31:0] second_x_i,
  input  logic [31:0] second_y_i,
  input  logic [31:0] second_z_i,
  input  logic [30:0] first_weight_i,
  input  logic [30:0] second_weight_i,
  input  logic [30:0] rest_length_i,
  input  logic [16:0] stiffness_i,
  input  dcp_q_stat_t q_stat_i,
  output logic        push_o,
  output dcp_item_t   item_o
);

  logic [2:0][31:0] p1, p2;
  logic [2:0][32:0] diff;

  assign p1 = {first_z_i, first_y_i, first_x_i};
  assign p2 = {second_z_i, second_y_i, second_x_i};

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // Difference per axis, sign and magnitude
  always_comb begin
    item_o = '0;
    for (int a = 0; a < 3; a++) begin
      diff[a]        = {p1[a][31], p1[a]} - {p2[a][31], p2[a]};
      item_o.dneg[a] = diff[a][32];
      item_o.mag[a]  = diff[a][32] ? (33'd0 - diff[a]) : diff[a];
    end
    item_o.p1   = p1;
    item_o.p2   = p2;
    item_o.w1   = first_weight_i;
    item_o.w2   = second_weight_i;
    item_o.wsum = {1'b0, first_weight_i} + {1'b0, second_weight_i};
    item_o.rest = rest_length_i;
    item_o.k    = (stiffness_i > Q_ONE) ? Q_ONE : stiffness_i;
  end

endmodule

[rtl/dcp_fifo.sv]
// ----------------------------------------------------------------------------
// dcp_fifo
// Short register queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module dcp_fifo import dcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  dcp_item_t   data_i,
  input  logic        pop_i,
  output dcp_item_t   data_o,
  output dcp_q_stat_t stat_o
);

  dcp_item_t          ent_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign data_o       = ent_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= data_i;
  end

endmodule

[rtl/dcp_back.sv]
// ----------------------------------------------------------------------------
// dcp_back
// Pipeline that carries out the projection: squares, bit-per-stage square
// root, weight ratios and direction quotients, products, then the move,
// saturation and status into the output register.
// ----------------------------------------------------------------------------
module dcp_back import dcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dcp_q_stat_t q_stat_i,
  input  dcp_item_t   q_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dcp_res_t    res_o
);

  dcp_pipe_t         pipe_q [NSTAGE];
  dcp_pipe_t         pipe_d [NSTAGE];
  logic [NSTAGE-1:0] vld_q;
  logic              out_vld_q;
  dcp_res_t          res_q, res_d;
  logic              en;

  // Whole pipeline moves unless the output register is held
  assign en          = !out_vld_q || out_ready_i;
  assign pop_o       = en && !q_stat_i.empty;
  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

  // Entry stage: squares and divider setup
  always_comb begin
    pipe_d[0]    = '0;
    pipe_d[0].it = q_data_i;
    for (int a = 0; a < 3; a++) begin
      pipe_d[0].sq[a] = {32'b0, q_data_i.mag[a]} * {32'b0, q_data_i.mag[a]};
    end
    pipe_d[0].ar[0] = {3'b0, q_data_i.w1};
    pipe_d[0].ar[1] = {3'b0, q_data_i.w2};
  end

  for (genvar j = 1; j < NSTAGE; j++) begin : g_stage
    localparam bit DO_ADIV  = (j >= ST_ADIV0) && (j <= ST_ADIV1);
    localparam bit DO_SQRT  = (j >= ST_SQRT0) && (j <= ST_SQRT1);
    localparam bit DO_UDIV  = (j >= ST_UDIV0) && (j <= ST_UDIV1);
    localparam int SB       = DO_SQRT ? (ST_SQRT1 - j) : 0;

    always_comb begin
      dcp_pipe_t   cur;
      dcp_pipe_t   nxt;
      logic [33:0] at;
      logic [34:0] ut;
      logic [67:0] trial;
      logic [33:0] sdiff;
      logic [49:0] fprod;
      logic [63:0] prod;
      logic        ge;
      cur   = pipe_q[j-1];
      nxt   = cur;
      at    = '0;
      ut    = '0;
      trial = '0;
      sdiff = '0;
      fprod = '0;
      prod  = '0;
      ge    = 1'b0;

      // Weight ratio w/(w1+w2) in Q1.30, one quotient bit per stage
      if (DO_ADIV) begin
        for (int a = 0; a < 2; a++) begin
          at         = cur.ar[a];
          ge         = (at >= {2'b0, cur.it.wsum});
          nxt.ar[a]  = (ge ? (at - {2'b0, cur.it.wsum}) : at) << 1;
          nxt.aq[a]  = {cur.aq[a][29:0], ge};
        end
      end

      // Sum of squares starts the root
      if (j == ST_SUM) begin
        nxt.rem  = 66'(cur.sq[0]) + 66'(cur.sq[1]) + 66'(cur.sq[2]);
        nxt.root = '0;
      end

      // Square root, one result bit per stage
      if (DO_SQRT) begin
        trial = ({35'b0, cur.root} << (SB + 1)) | (68'd1 << (2 * SB));
        ge    = ({2'b0, cur.rem} >= trial);
        if (ge) begin
          nxt.rem  = cur.rem - trial[65:0];
          nxt.root = cur.root | (33'd1 << SB);
        end
      end

      // Stretch and direction divider setup
      if (j == ST_SDIFF) begin
        sdiff    = {1'b0, cur.root} - {3'b0, cur.it.rest};
        nxt.sneg = sdiff[33];
        nxt.sabs = sdiff[33] ? 33'(34'd0 - sdiff) : sdiff[32:0];
        for (int a = 0; a < 3; a++) begin
          nxt.ur[a] = {2'b0, cur.it.mag[a]};
          nxt.uq[a] = '0;
        end
      end

      // Scaled stretch
      if (j == ST_FM) begin
        fprod  = cur.sabs * cur.it.k;
        nxt.fm = fprod[48:16];
      end

      // Direction |d|/len in Q1.30, one quotient bit per stage
      if (DO_UDIV) begin
        for (int a = 0; a < 3; a++) begin
          ut        = cur.ur[a];
          ge        = (ut >= {2'b0, cur.root});
          nxt.ur[a] = (ge ? (ut - {2'b0, cur.root}) : ut) << 1;
          nxt.uq[a] = {cur.uq[a][29:0], ge};
        end
      end

      // Correction along each axis
      if (j == ST_E) begin
        for (int a = 0; a < 3; a++) begin
          prod     = cur.fm * cur.uq[a];
          nxt.e[a] = prod[62:30];
        end
      end

      // Split by weight ratio
      if (j == ST_MV) begin
        for (int a = 0; a < 3; a++) begin
          prod       = cur.e[a] * cur.aq[0];
          nxt.mv1[a] = prod[62:30];
          prod       = cur.e[a] * cur.aq[1];
          nxt.mv2[a] = prod[62:30];
        end
      end

      pipe_d[j] = nxt;
    end
  end

  // Apply moves, saturate, pick status
  always_comb begin
    dcp_pipe_t          cur;
    logic               neg;
    logic signed [34:0] d1, d2;
    logic signed [35:0] n1w, n2w;
    logic               sat;
    cur   = pipe_q[NSTAGE-1];
    res_d = '0;
    sat   = 1'b0;
    neg   = 1'b0;
    d1    = '0;
    d2    = '0;
    n1w   = '0;
    n2w   = '0;
    res_d.n1 = cur.it.p1;
    res_d.n2 = cur.it.p2;
    if (cur.root == '0) begin
      res_d.status = ST_ZERO_LEN;
    end else if (cur.it.wsum == '0) begin
      res_d.status = ST_ZERO_WSUM;
    end else begin
      for (int a = 0; a < 3; a++) begin
        neg = cur.sneg ^ cur.it.dneg[a];
        d1  = neg ? -$signed({2'b0, cur.mv1[a]}) : $signed({2'b0, cur.mv1[a]});
        d2  = neg ? -$signed({2'b0, cur.mv2[a]}) : $signed({2'b0, cur.mv2[a]});
        n1w = $signed({{4{cur.it.p1[a][31]}}, cur.it.p1[a]}) - $signed({d1[34], d1});
        n2w = $signed({{4{cur.it.p2[a][31]}}, cur.it.p2[a]}) + $signed({d2[34], d2});
        if (cur.it.w1 != '0) begin
          if (n1w[35:31] != {5{n1w[35]}}) begin
            sat          = 1'b1;
            res_d.n1[a]  = n1w[35] ? SAT_NEG : SAT_POS;
          end else begin
            res_d.n1[a]  = n1w[31:0];
          end
        end
        if (cur.it.w2 != '0) begin
          if (n2w[35:31] != {5{n2w[35]}}) begin
            sat          = 1'b1;
            res_d.n2[a]  = n2w[35] ? SAT_NEG : SAT_POS;
          end else begin
            res_d.n2[a]  = n2w[31:0];
          end
        end
      end
      res_d.status = sat ? ST_SATURATED : ST_APPLIED;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NSTAGE-2:0], pop_o};
      out_vld_q <= vld_q[NSTAGE-1];
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q <= pipe_d;
      res_q  <= res_d;
    end
  end

endmodule

[rtl/distance_constraint_projection.sv]
// ----------------------------------------------------------------------------
// distance_constraint_projection
// Position based dynamics distance constraint in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries two points, their inverse
//   masses, rest length and stiffness. Output channel out_valid_o/out_ready_i
//   returns both corrected points and a status, one result per request,
//   in request order.
//   The 33-stage square root is followed by the 31-stage direction
//   divider, each producing one bit per stage. Throughput is one request
//   per cycle when the output is not stalled.
//   A four-entry queue sits between the classifying front and the back
//   pipeline. While a result waits and out_ready_i is low, the back holds;
//   the front takes requests until the queue fills, then drops in_ready_o.
//   Reset clears the queue, the pipeline valid bits and the output valid
//   flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module distance_constraint_projection import dcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] first_x_i,
  input  logic [31:0] first_y_i,
  input  logic [31:0] first_z_i,
  input  logic [31:0] second_x_i,
  input  logic [31:0] second_y_i,
  input  logic [31:0] second_z_i,
  input  logic [30:0] first_weight_i,
  input  logic [30:0] second_weight_i,
  input  logic [30:0] rest_length_i,
  input  logic [16:0] stiffness_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_first_x_o,
  output logic [31:0] new_first_y_o,
  output logic [31:0] new_first_z_o,
  output logic [31:0] new_second_x_o,
  output logic [31:0] new_second_y_o,
  output logic [31:0] new_second_z_o,
  output logic [1:0]  status_o
);

  dcp_q_stat_t q_stat;
  dcp_item_t   push_item, q_head;
  logic        q_push, q_pop;
  dcp_res_t    res;

  dcp_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .first_z_i       (first_z_i),
    .second_x_i      (second_x_i),
    .second_y_i      (second_y_i),
    .second_z_i      (second_z_i),
    .first_weight_i  (first_weight_i),
    .second_weight_i (second_weight_i),
    .rest_length_i   (rest_length_i),
    .stiffness_i     (stiffness_i),
    .q_stat_i        (q_stat),
    .push_o          (q_push),
    .item_o          (push_item)
  );

  dcp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (push_item),
    .pop_i  (q_pop),
    .data_o (q_head),
    .stat_o (q_stat)
  );

  dcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_data_i    (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign new_first_x_o  = res.n1[0];
  assign new_first_y_o  = res.n1[1];
  assign new_first_z_o  = res.n1[2];
  assign new_second_x_o = res.n2[0];
  assign new_second_y_o = res.n2[1];
  assign new_second_z_o = res.n2[2];
  assign status_o       = res.status;

  // The back never takes from an empty queue
  `ASSERT_NEVER(a_pop_empty, q_pop && q_stat.empty)
  // An accepted request is queued in the next cycle
  `ASSERT_PROP(a_push_lands, (in_valid_i && in_ready_o) |=> !q_stat.empty)
  // A full queue with no pop stays full
  `ASSERT_PROP(a_full_holds, (q_stat.full && !q_pop) |=> q_stat.full)

endmodule

[dv/distance_constraint_projection_test.sv]
// ----------------------------------------------------------------------------
// distance_constraint_projection_test
// Streams constraint requests through the projection block with random
// idling on both sides and compares every result against a fixed point
// predictor of the constraint correction.
// ----------------------------------------------------------------------------
module distance_constraint_projection_test import dcp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] p1 [3];
    logic [31:0] p2 [3];
    logic [30:0] w1;
    logic [30:0] w2;
    logic [30:0] rest;
    logic [16:0] k;
  } constraint_req_t;

  typedef struct {
    logic [31:0] n1 [3];
    logic [31:0] n2 [3];
    dcp_status_e status;
  } projected_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic [31:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic [30:0] first_weight_i = '0, second_weight_i = '0, rest_length_i = '0;
  logic [16:0] stiffness_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] new_first_x_o, new_first_y_o, new_first_z_o;
  logic [31:0] new_second_x_o, new_second_y_o, new_second_z_o;
  logic [1:0]  status_o;

  constraint_req_t pending_reqs [$];
  projected_t      expected_projections [$];
  int  mismatches = 0;
  bit  idle_free = 1'b0;
  int  cycle_cnt = 0;

  distance_constraint_projection dut (.*);

  always #6 clk_i = ~clk_i;

  // Floor square root of a 66 bit value
  function automatic logic [32:0] int_sqrt(logic [65:0] v);
    logic [32:0] r;
    logic [32:0] c;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (33'd1 << b);
      if ({33'd0, c} * {33'd0, c} <= {62'd0, v}) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return SAT_POS;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return SAT_NEG;
    end
    return v[31:0];
  endfunction

  // Project one distance constraint
  function automatic projected_t project(constraint_req_t r);
    projected_t  o;
    longint      a [3], b [3], d [3];
    logic [65:0] sum;
    logic [32:0] len;
    logic [63:0] wsum, kk, fm, a1, a2, u, e, m;
    longint      s, m1, m2;
    bit          sat, neg;
    sum = '0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(r.p1[i]));
      b[i] = longint'($signed(r.p2[i]));
      d[i] = a[i] - b[i];
      m = d[i] < 0 ? -d[i] : d[i];
      sum += {2'b0, m * m};
      o.n1[i] = r.p1[i];
      o.n2[i] = r.p2[i];
    end
    len = int_sqrt(sum);
    wsum = 64'(r.w1) + 64'(r.w2);
    kk = r.k > Q_ONE ? 64'(Q_ONE) : 64'(r.k);
    if (len == 0) o.status = ST_ZERO_LEN;
    else if (wsum == 0) o.status = ST_ZERO_WSUM;
    else begin
      s = longint'(len) - longint'(r.rest);
      fm = ((s < 0 ? -s : s) * kk) >> 16;
      a1 = (64'(r.w1) << 30) / wsum;
      a2 = (64'(r.w2) << 30) / wsum;
      for (int i = 0; i < 3; i++) begin
        m = d[i] < 0 ? -d[i] : d[i];
        u = (m << 30) / 64'(len);
        e = (fm * u) >> 30;
        m1 = longint'((e * a1) >> 30);
        m2 = longint'((e * a2) >> 30);
        neg = (s < 0) != (d[i] < 0);
        if (neg) begin
          m1 = -m1;
          m2 = -m2;
        end
        if (r.w1 > 0) o.n1[i] = clamp32(a[i] - m1, sat);
        if (r.w2 > 0) o.n2[i] = clamp32(b[i] + m2, sat);
      end
      o.status = sat ? ST_SATURATED : ST_APPLIED;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic constraint_req_t rand_req();
    constraint_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.p1[i] = rand_coord();
      r.p2[i] = $urandom_range(0, 7) == 0 ? r.p1[i] : rand_coord();
    end
    r.w1 = $urandom_range(0, 5) == 0 ? '0 : ($urandom_range(0, 3) == 0 ? 31'($urandom)
                                          : 31'($urandom_range(1, 32'h0004_0000)));
    r.w2 = $urandom_range(0, 5) == 0 ? '0 : ($urandom_range(0, 3) == 0 ? 31'($urandom)
                                          : 31'($urandom_range(1, 32'h0004_0000)));
    r.rest = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0100_0000));
    case ($urandom_range(0, 3))
      0: r.k = Q_ONE;
      1: r.k = 17'($urandom);
      default: r.k = 17'($urandom_range(0, 65536));
    endcase
    return r;
  endfunction

  // Fill the request queue: directed corners first, then random
  initial begin
    constraint_req_t r;
    r = rand_req();
    for (int c = 0; c < 14; c++) begin
      r = rand_req();
      r.k = Q_ONE;
      r.w1 = 31'h0001_0000;
      r.w2 = 31'h0001_0000;
      case (c)
        0: r.p2 = r.p1;
        1: begin r.w1 = '0; r.w2 = '0; end
        2: begin r.p2 = r.p1; r.w1 = '0; r.w2 = '0; end
        3: r.w1 = '0;
        4: r.w2 = '0;
        5: r.k = 17'h1FFFF;
        6: r.k = '0;
        7: begin r.p1 = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
                 r.p2 = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; r.rest = '0; end
        8: begin r.p1 = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
                 r.p2 = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; r.rest = '0; end
        9: begin r.w1 = 31'h7FFF_FFFF; r.w2 = 31'h7FFF_FFFF; r.rest = 31'h7FFF_FFFF; end
        10: begin r.p1 = '{32'h0001_0000, 0, 0}; r.p2 = '{0, 0, 0}; r.rest = 31'h0002_0000; end
        11: begin r.p1 = '{0, 32'hFFFF_0000, 0}; r.p2 = '{0, 0, 0}; r.rest = '0; end
        12: begin r.p1 = '{0, 0, 1}; r.p2 = '{0, 0, 0}; r.rest = 31'h7FFF_FFFF; end
        13: begin r.p1 = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                  r.w1 = 31'h7FFF_FFFF; r.w2 = 31'h7FFF_FFFF; end
        default: ;
      endcase
      pending_reqs.insert(pending_reqs.size(), r);
    end
    for (int n = 0; n < 1200; n++) pending_reqs.insert(pending_reqs.size(), rand_req());
  end

  // Reset, free running phase, end of run
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (1500) @(posedge clk_i);
    idle_free <= 1'b1;
    repeat (600) @(posedge clk_i);
    idle_free <= 1'b0;
    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_projections.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  // Cycles since reset release; sets the long receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) cycle_cnt <= cycle_cnt + 1;
  end

  // Driver
  always @(posedge clk_i) begin
    constraint_req_t r;
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) begin
          r.p1 = '{first_x_i, first_y_i, first_z_i};
          r.p2 = '{second_x_i, second_y_i, second_z_i};
          r.w1 = first_weight_i;
          r.w2 = second_weight_i;
          r.rest = rest_length_i;
          r.k = stiffness_i;
          expected_projections.insert(expected_projections.size(), project(r));
        end
        if (pending_reqs.size() > 0 && (idle_free || $urandom_range(0, 99) >= 26)) begin
          r = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          first_x_i <= r.p1[0]; first_y_i <= r.p1[1]; first_z_i <= r.p1[2];
          second_x_i <= r.p2[0]; second_y_i <= r.p2[1]; second_z_i <= r.p2[2];
          first_weight_i <= r.w1;
          second_weight_i <= r.w2;
          rest_length_i <= r.rest;
          stiffness_i <= r.k;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall control and result check
  always @(posedge clk_i) begin
    projected_t x;
    if (rst_ni) begin
      out_ready_i <= (cycle_cnt < 300 || cycle_cnt >= 500) &&
                     (idle_free || $urandom_range(0, 99) >= 26);
      if (out_valid_o && out_ready_i) begin
        if (expected_projections.size() == 0) begin
          report_mismatch("unexpected result", status_o, 0);
        end else begin
          x = expected_projections.pop_front();
          if (new_first_x_o !== x.n1[0]) report_mismatch("new_first_x", new_first_x_o, x.n1[0]);
          if (new_first_y_o !== x.n1[1]) report_mismatch("new_first_y", new_first_y_o, x.n1[1]);
          if (new_first_z_o !== x.n1[2]) report_mismatch("new_first_z", new_first_z_o, x.n1[2]);
          if (new_second_x_o !== x.n2[0])
            report_mismatch("new_second_x", new_second_x_o, x.n2[0]);
          if (new_second_y_o !== x.n2[1])
            report_mismatch("new_second_y", new_second_y_o, x.n2[1]);
          if (new_second_z_o !== x.n2[2])
            report_mismatch("new_second_z", new_second_z_o, x.n2[2]);
          if (status_o !== x.status) report_mismatch("status", status_o, x.status);
        end
      end
    end
  end
endmodule

[files.f]
+incdir+rtl
rtl/dcp_pkg.sv
rtl/dcp_front.sv
rtl/dcp_fifo.sv
rtl/dcp_back.sv
rtl/distance_constraint_projection.sv
dv/distance_constraint_projection_test.sv
